>>> hw/rtl/iss_pkg.sv
`default_nettype none

package iss_pkg;

   localparam int unsigned DATA_W = 32;

   // controller states, one-hot
   typedef enum logic [1:0] {
      ST_COLLECT = 2'b01,
      ST_EMIT    = 2'b10
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic insert;     // insert request value into the chain
      logic drop;       // chain full: discard and flag overflow
      logic shift_out;  // result taken: move entries down one place
      logic clear;      // end of set: clear overflow flag
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;       // every cell holds an entry
      logic one_left;   // exactly one entry remains
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/iss_ctrl.sv
`default_nettype none

module iss_ctrl
   import iss_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire        req_tlast,
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.insert = ~status.full;
               cmd.drop   = status.full;
               if (req_tlast) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.shift_out = 1'b1;
               if (status.one_left) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_COLLECT;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/iss_datapath.sv
`default_nettype none

module iss_datapath
   import iss_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
)
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire signed [DATA_W-1:0]  in_value,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic signed [DATA_W-1:0] out_value,
   output logic                     out_dropped
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   logic signed [DATA_W-1:0] cell_ff [CAPACITY];
   logic signed [DATA_W-1:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0]      gt;
   logic [CAPACITY-1:0]      wr;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     ovf_ff, ovf_in;

   // Each cell compares against the new value in parallel. Occupied cells
   // holding a strictly greater value take their lower neighbor (or the new
   // value at the boundary); the first free cell takes the same choice.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (cell_ff[i] > in_value);
         wr[i] = gt[i] || (CNT_W'(i) == count_ff);
      end
      for (int i = 0; i < CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.shift_out) begin
            if (i < CAPACITY - 1) begin
               cell_in[i] = cell_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end else if (cmd.insert && wr[i]) begin
            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end else begin
               cell_in[i] = in_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.shift_out) begin
         count_in = count_ff - CNT_W'(1);
      end
      ovf_in = ovf_ff;
      if (cmd.drop) begin
         ovf_in = 1'b1;
      end else if (cmd.clear) begin
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign status.full     = (count_ff == CNT_W'(CAPACITY));
   assign status.one_left = (count_ff == CNT_W'(1));
   assign out_value       = cell_ff[0];
   assign out_dropped     = ovf_ff;

endmodule

`default_nettype wire

>>> hw/rtl/insertion_sort_stream_core.sv
`default_nettype none

// Stable ascending stream sorter for signed 32-bit values. Requests arrive
// on req_* one per cycle while the block collects a set; each value enters
// a chain of CAPACITY compare-and-shift cells in the cycle it is accepted,
// so collection runs at one request per clock. The request flagged by
// req_tlast closes the set: the block then stops taking requests and sends
// every stored value on rsp_* in ascending order, one result per cycle while
// rsp_tready is high, straight from the bottom cell of the chain; equal
// values leave in arrival order. rsp_tlast marks the final result of the set
// and rsp_tuser is high on every result of a set in which requests arrived
// while all cells were full (those requests are discarded). The first
// request of the next set is taken in the cycle after the last result is
// accepted. No clearing pass is needed after reset.

module insertion_sort_stream_core
   import iss_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
)
(
   input  wire               clock,
   input  wire               reset,
   // request channel
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire [DATA_W-1:0]  req_tdata,   // [31:0] value
   input  wire               req_tlast,   // last_in
   // result channel
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [31:0] sorted_value
   output logic              rsp_tlast,   // last_out
   output logic              rsp_tuser    // [0] dropped
);

   cmd_type                  cmd;
   status_type               status;
   logic signed [DATA_W-1:0] head_value;

   iss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   iss_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .in_value    (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .out_value   (head_value),
      .out_dropped (rsp_tuser)
   );

   // results come straight off the bottom cell; last when one entry remains
   assign rsp_tdata = head_value;
   assign rsp_tlast = status.one_left;

endmodule

`default_nettype wire
